/* src/qrs_pkg.sv */
package qrs_pkg;

  localparam int WORD_BITS     = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int LIMIT_W       = 31;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(1);
  localparam int CFG_DW        = 32;
  localparam int CFG_AW        = 3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_QUAD = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] coef_a;
    logic signed [WORD_BITS-1:0] coef_b;
    logic signed [WORD_BITS-1:0] coef_c;
  } in_req_t;

  typedef struct packed {
    logic [1:0]                  status;
    logic signed [WORD_BITS-1:0] root_one_real;
    logic signed [WORD_BITS-1:0] root_one_imag;
    logic signed [WORD_BITS-1:0] root_two_real;
    logic signed [WORD_BITS-1:0] root_two_imag;
  } out_res_t;

  // per-request side data carried down the discriminant and sqrt stages
  typedef struct packed {
    logic                 a_neg;
    logic                 b_neg;
    logic                 d_neg;
    logic                 d_tiny;
    logic                 not_quad;
    logic [WORD_BITS-1:0] a_mag;
    logic [WORD_BITS-1:0] b_mag;
  } side_t;

endpackage

/* src/qrs_div.sv */
module qrs_div #(
  parameter int MAG_W  = 34,
  parameter int FRAC_W = 16,
  parameter int QUO_W  = 32
) (
  input  logic             clk,
  input  logic [MAG_W-1:0] mag_i,
  input  logic             neg_i,
  input  logic [QUO_W:0]   den_i,
  output logic [QUO_W-1:0] res_o,
  output logic             ovf_o
);

  localparam int NW  = MAG_W + FRAC_W;
  localparam int HW  = NW - QUO_W;
  localparam int DNW = QUO_W + 1;
  localparam int CPW = HW + DNW;

  logic [NW-1:0]    num;
  logic [HW-1:0]    num_hi;

  logic [DNW-1:0]   rem_r [0:QUO_W];
  logic [QUO_W-1:0] lo_r  [0:QUO_W];
  logic [QUO_W-1:0] q_r   [0:QUO_W];
  logic [DNW-1:0]   den_r [0:QUO_W];
  logic             neg_r [0:QUO_W];
  logic             hi_r  [0:QUO_W];

  logic [QUO_W-1:0] lim;

  assign num    = {mag_i, {FRAC_W{1'b0}}};
  assign num_hi = num[NW-1:QUO_W];

  // quotient of 2^QUO_W or more is flagged up front; remainder then starts below den
  always_ff @(posedge clk) begin
    rem_r[0] <= DNW'(CPW'(num_hi));
    lo_r[0]  <= num[QUO_W-1:0];
    q_r[0]   <= '0;
    den_r[0] <= den_i;
    neg_r[0] <= neg_i;
    hi_r[0]  <= CPW'(num_hi) >= CPW'(den_i);
  end

  for (genvar j = 0; j < QUO_W; j++) begin : g_step
    logic [DNW:0] r2;
    logic [DNW:0] dx;
    logic [DNW:0] df;
    logic         ge;

    assign r2 = {rem_r[j], lo_r[j][QUO_W-1]};
    assign dx = {1'b0, den_r[j]};
    assign df = r2 - dx;
    assign ge = r2 >= dx;

    always_ff @(posedge clk) begin
      rem_r[j+1] <= ge ? df[DNW-1:0] : r2[DNW-1:0];
      q_r[j+1]   <= {q_r[j][QUO_W-2:0], ge};
      lo_r[j+1]  <= lo_r[j] << 1;
      den_r[j+1] <= den_r[j];
      neg_r[j+1] <= neg_r[j];
      hi_r[j+1]  <= hi_r[j];
    end
  end

  assign lim = neg_r[QUO_W] ? {1'b1, {(QUO_W-1){1'b0}}} : {1'b0, {(QUO_W-1){1'b1}}};

  always_ff @(posedge clk) begin
    ovf_o <= hi_r[QUO_W] | (q_r[QUO_W] > lim);
    res_o <= neg_r[QUO_W] ? (~q_r[QUO_W] + 1'b1) : q_r[QUO_W];
  end

endmodule

/* src/quadratic_root_solver_unit.sv */
// Throughput: one request per cycle; busy is never raised.
// Depth is set by the bit-per-stage square root (WORD_BITS+1) and divider (WORD_BITS+2) pipes.
// Reset (rst_n low, synchronous) clears all valid bits and sets near_zero_limit to 1.
// The receiver cannot stall: each result is shown for exactly one cycle on out_valid.
module quadratic_root_solver_unit #(
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  qrs_pkg::in_req_t             in_req,
  output logic                         out_valid,
  output qrs_pkg::out_res_t            out_res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [qrs_pkg::CFG_AW-1:0]   paddr,
  input  logic [qrs_pkg::CFG_DW-1:0]   pwdata,
  output logic [qrs_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready
);

  localparam int W   = qrs_pkg::WORD_BITS;
  localparam int LW  = qrs_pkg::LIMIT_W;
  localparam int DW  = 2 * W + 2;
  localparam int SW  = W + 1;
  localparam int RW  = SW + 2;
  localparam int TW  = SW + 4;
  localparam int MW  = W + 2;
  localparam int CW  = W + LW;
  localparam int NST = 2 * W + 10;
  localparam int DL  = W + 2;

  // configuration
  logic [LW-1:0] lim_r;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & ~paddr[2];
  assign prdata = paddr[2] ? '0 : {{(qrs_pkg::CFG_DW-LW){1'b0}}, lim_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= qrs_pkg::LIMIT_RST;
    end else if (cfg_wr) begin
      lim_r <= pwdata[LW-1:0];
    end
  end

  // valid chain
  logic [NST-1:0] vld_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NST-2:0], start & ~busy};
    end
  end

  // s0: capture
  logic [W-1:0] a0_r, b0_r, c0_r;

  always_ff @(posedge clk) begin
    a0_r <= in_req.coef_a;
    b0_r <= in_req.coef_b;
    c0_r <= in_req.coef_c;
  end

  // s1: sign / magnitude
  logic         sa1_r, sb1_r, sc1_r;
  logic [W-1:0] ma1_r, mb1_r, mc1_r;

  always_ff @(posedge clk) begin
    sa1_r <= a0_r[W-1];
    sb1_r <= b0_r[W-1];
    sc1_r <= c0_r[W-1];
    ma1_r <= a0_r[W-1] ? (~a0_r + 1'b1) : a0_r;
    mb1_r <= b0_r[W-1] ? (~b0_r + 1'b1) : b0_r;
    mc1_r <= c0_r[W-1] ? (~c0_r + 1'b1) : c0_r;
  end

  // s2: products
  logic [2*W-1:0]      p2_r, m2_r;
  logic                sc2_r;
  qrs_pkg::side_t      sd2_r;

  always_ff @(posedge clk) begin
    p2_r           <= mb1_r * mb1_r;
    m2_r           <= ma1_r * mc1_r;
    sc2_r          <= sc1_r;
    sd2_r.a_neg    <= sa1_r;
    sd2_r.b_neg    <= sb1_r;
    sd2_r.d_neg    <= 1'b0;
    sd2_r.d_tiny   <= 1'b0;
    sd2_r.not_quad <= (ma1_r == '0) || (CW'(ma1_r) < CW'(lim_r));
    sd2_r.a_mag    <= ma1_r;
    sd2_r.b_mag    <= mb1_r;
  end

  // s3: discriminant magnitude and sign
  logic [DW-1:0]  pp, qq;
  logic [DW-1:0]  dmag3_nxt;
  logic [DW-1:0]  dmag3_r;
  qrs_pkg::side_t sd3_nxt;
  qrs_pkg::side_t sd3_r;

  assign pp = {2'b00, p2_r};
  assign qq = {m2_r, 2'b00};

  always_comb begin
    sd3_nxt = sd2_r;
    if (sd2_r.a_neg ^ sc2_r) begin
      dmag3_nxt     = pp + qq;
      sd3_nxt.d_neg = 1'b0;
    end else if (pp >= qq) begin
      dmag3_nxt     = pp - qq;
      sd3_nxt.d_neg = 1'b0;
    end else begin
      dmag3_nxt     = qq - pp;
      sd3_nxt.d_neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    dmag3_r <= dmag3_nxt;
    sd3_r   <= sd3_nxt;
  end

  // s4 and square root, two radicand bits per stage
  logic [DW-1:0]  thr;
  logic           tiny;
  qrs_pkg::side_t sd0_nxt;
  logic [DW-1:0]  rad_r  [0:SW];
  logic [RW-1:0]  rem_r  [0:SW];
  logic [SW-1:0]  root_r [0:SW];
  qrs_pkg::side_t sd_r   [0:SW];

  assign thr  = DW'(lim_r) << FRAC_BITS;
  assign tiny = dmag3_r < thr;

  always_comb begin
    sd0_nxt        = sd3_r;
    sd0_nxt.d_tiny = tiny;
  end

  always_ff @(posedge clk) begin
    rad_r[0]        <= tiny ? '0 : dmag3_r;
    rem_r[0]        <= '0;
    root_r[0]       <= '0;
    sd_r[0]         <= sd0_nxt;
  end

  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    logic [TW-1:0] rt, tt, df;
    logic          ge;

    assign rt = {rem_r[k], rad_r[k][DW-1 -: 2]};
    assign tt = {2'b00, root_r[k], 2'b01};
    assign df = rt - tt;
    assign ge = rt >= tt;

    always_ff @(posedge clk) begin
      rad_r[k+1]  <= rad_r[k] << 2;
      rem_r[k+1]  <= ge ? df[RW-1:0] : rt[RW-1:0];
      root_r[k+1] <= {root_r[k][SW-2:0], ge};
      sd_r[k+1]   <= sd_r[k];
    end
  end

  // prep: numerators for the four root parts
  function automatic logic [MW:0] smadd(input logic s1, input logic [MW-1:0] m1,
                                        input logic s2, input logic [MW-1:0] m2);
    logic [MW:0] r;
    if (s1 == s2) begin
      r = {s1, m1 + m2};
    end else if (m1 >= m2) begin
      r = {s1, m1 - m2};
    end else begin
      r = {s2, m2 - m1};
    end
    return r;
  endfunction

  qrs_pkg::side_t sq;
  logic [MW-1:0]  s_ext, b_ext;
  logic [MW:0]    sm1, sm2;
  logic [MW-1:0]  nm_nxt [0:3];
  logic           ng_nxt [0:3];
  logic [MW-1:0]  nm_r   [0:3];
  logic           ng_r   [0:3];
  logic [W:0]     den_r;
  logic           pq_r;

  assign sq    = sd_r[SW];
  assign s_ext = MW'(root_r[SW]);
  assign b_ext = MW'(sq.b_mag);
  assign sm1   = smadd(~sq.b_neg, b_ext, 1'b0, s_ext);
  assign sm2   = smadd(~sq.b_neg, b_ext, 1'b1, s_ext);

  always_comb begin
    if (sq.d_tiny || !sq.d_neg) begin
      nm_nxt[0] = sm1[MW-1:0];
      ng_nxt[0] = sm1[MW];
      nm_nxt[1] = '0;
      ng_nxt[1] = 1'b0;
      nm_nxt[2] = sm2[MW-1:0];
      ng_nxt[2] = sm2[MW];
      nm_nxt[3] = '0;
      ng_nxt[3] = 1'b0;
    end else begin
      nm_nxt[0] = b_ext;
      ng_nxt[0] = ~sq.b_neg;
      nm_nxt[1] = s_ext;
      ng_nxt[1] = 1'b0;
      nm_nxt[2] = b_ext;
      ng_nxt[2] = ~sq.b_neg;
      nm_nxt[3] = s_ext;
      ng_nxt[3] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      nm_r[i] <= nm_nxt[i];
      ng_r[i] <= ng_nxt[i] ^ sq.a_neg;
    end
    den_r <= {sq.a_mag, 1'b0};
    pq_r  <= sq.not_quad;
  end

  // dividers
  logic [W-1:0] dres [0:3];
  logic [3:0]   dovf;

  for (genvar i = 0; i < 4; i++) begin : g_div
    qrs_div #(
      .MAG_W  (MW),
      .FRAC_W (FRAC_BITS),
      .QUO_W  (W)
    ) u_div (
      .clk   (clk),
      .mag_i (nm_r[i]),
      .neg_i (ng_r[i]),
      .den_i (den_r),
      .res_o (dres[i]),
      .ovf_o (dovf[i])
    );
  end

  logic nqd_r [0:DL-1];

  always_ff @(posedge clk) begin
    nqd_r[0] <= pq_r;
    for (int j = 1; j < DL; j++) begin
      nqd_r[j] <= nqd_r[j-1];
    end
  end

  // output
  qrs_pkg::out_res_t out_nxt;
  qrs_pkg::out_res_t out_r;

  always_comb begin
    out_nxt = '0;
    if (nqd_r[DL-1]) begin
      out_nxt.status = qrs_pkg::ST_NOT_QUAD;
    end else if (|dovf) begin
      out_nxt.status = qrs_pkg::ST_OVERFLOW;
    end else begin
      out_nxt.status        = qrs_pkg::ST_OK;
      out_nxt.root_one_real = dres[0];
      out_nxt.root_one_imag = dres[1];
      out_nxt.root_two_real = dres[2];
      out_nxt.root_two_imag = dres[3];
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_res   = out_r;
  assign out_valid = vld_r[NST-1];

endmodule
